// ===== hw/rtl/ppmsum_pkg.sv =====
`timescale 1ns / 1ps

package ppmsum_pkg;

    localparam int SLOT_COUNT_DEF   = 10;
    localparam int WIDTH_W          = 16;
    localparam int CNT_W            = 5;
    localparam int IDX_W            = 4;
    localparam int CFG_IDX_W        = 2;
    localparam int QUEUE_DEPTH      = 2;
    localparam int QPTR_W           = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

    localparam logic [WIDTH_W-1:0] SYNC_RESET   = WIDTH_W'(8000);
    localparam logic [WIDTH_W-1:0] RELOAD_RESET = WIDTH_W'(60000);
    localparam logic [CNT_W-1:0]   MINCH_RESET  = CNT_W'(5);

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_RELOAD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CHANNELS   = 2'd2;

    typedef enum logic [1:0] {
        K_CAPTURE,
        K_IGNORE,
        K_READ
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_COMMIT
    } t_state;

    typedef struct packed {
        t_kind              kind;
        logic [WIDTH_W-1:0] capture_count;
        logic [IDX_W-1:0]   channel_index;
    } t_op;

    typedef struct packed {
        logic [WIDTH_W-1:0] sync_threshold;
        logic [WIDTH_W-1:0] timer_reload;
        logic [CNT_W-1:0]   min_channels;
    } t_cfg;

endpackage

// ===== hw/rtl/ppmsum_front.sv =====
`timescale 1ns / 1ps

module ppmsum_front
    import ppmsum_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_mode,
    input  logic [WIDTH_W-1:0] i_capture_count,
    input  logic               i_overcapture,
    input  logic [IDX_W-1:0]   i_channel_index,
    output logic               o_push,
    output t_op                o_op,
    input  logic               i_full
);

    logic r_valid;
    t_op  r_op;
    logic n_valid;
    t_op  n_op;
    logic w_take;

    assign o_push     = r_valid && !i_full;
    assign o_in_ready = !r_valid || !i_full;
    assign w_take     = i_in_valid && o_in_ready;
    assign o_op       = r_op;

    always_comb begin
        n_valid = r_valid;
        n_op    = r_op;
        if (o_push) begin
            n_valid = 1'b0;
        end
        if (w_take) begin
            n_valid = 1'b1;
            // overcapture only matters for capture items
            if (i_mode) begin
                n_op.kind = K_READ;
            end else if (i_overcapture) begin
                n_op.kind = K_IGNORE;
            end else begin
                n_op.kind = K_CAPTURE;
            end
            n_op.capture_count = i_capture_count;
            n_op.channel_index = i_channel_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_op <= n_op;
    end

endmodule

// ===== hw/rtl/ppmsum_fifo.sv =====
`timescale 1ns / 1ps

module ppmsum_fifo
    import ppmsum_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    input  logic i_pop,
    output t_op  o_op,
    output logic o_empty
);

    t_op               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_op    = r_mem[r_rd];

    function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_next(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_next(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

endmodule

// ===== hw/rtl/ppmsum_back.sv =====
`timescale 1ns / 1ps

module ppmsum_back
    import ppmsum_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_empty,
    input  t_op                i_op,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [WIDTH_W-1:0] o_read_value,
    output logic [CNT_W-1:0]   o_channel_count,
    output logic               o_sample_ignored,
    output logic               o_sync_detected,
    output logic               o_frame_published
);

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [CNT_W-1:0] NCH = CNT_W'(SLOT_COUNT);

    t_state             r_state, n_state;
    t_op                r_op, n_op;
    logic [WIDTH_W-1:0] r_width, n_width;
    logic               r_sync, n_sync;
    logic [WIDTH_W-1:0] r_prev, n_prev;
    logic [CNT_W-1:0]   r_slot, n_slot;
    logic [CNT_W-1:0]   r_pub, n_pub;
    logic [WIDTH_W-1:0] r_widths [SLOT_COUNT];
    logic [WIDTH_W-1:0] n_widths [SLOT_COUNT];

    logic               r_out_valid, n_out_valid;
    logic [WIDTH_W-1:0] r_rv, n_rv;
    logic [CNT_W-1:0]   r_cc, n_cc;
    logic               r_ign, n_ign;
    logic               r_syn, n_syn;
    logic               r_fp, n_fp;

    logic [WIDTH_W+1:0] w_diff;
    logic [WIDTH_W-1:0] w_width;

    // unwrap at the reload value; a negative result clamps to zero, an overflow to all ones
    always_comb begin
        if (r_op.capture_count >= r_prev) begin
            w_diff = {2'b00, r_op.capture_count} - {2'b00, r_prev};
        end else begin
            w_diff = {2'b00, r_op.capture_count} + {2'b00, i_cfg.timer_reload}
                     - {2'b00, r_prev};
        end
        if (w_diff[WIDTH_W+1]) begin
            w_width = '0;
        end else if (w_diff[WIDTH_W]) begin
            w_width = '1;
        end else begin
            w_width = w_diff[WIDTH_W-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_width     = r_width;
        n_sync      = r_sync;
        n_prev      = r_prev;
        n_slot      = r_slot;
        n_pub       = r_pub;
        n_widths    = r_widths;
        n_out_valid = r_out_valid;
        n_rv        = r_rv;
        n_cc        = r_cc;
        n_ign       = r_ign;
        n_syn       = r_syn;
        n_fp        = r_fp;
        o_pop       = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_op    = i_op;
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                n_width = w_width;
                n_sync  = (w_width > i_cfg.sync_threshold);
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_rv  = '0;
                    n_ign = 1'b0;
                    n_syn = 1'b0;
                    n_fp  = 1'b0;
                    case (r_op.kind)
                        K_READ: begin
                            if (CNT_W'(r_op.channel_index) < NCH) begin
                                n_rv = r_widths[r_op.channel_index[IW-1:0]];
                            end
                        end
                        K_IGNORE: begin
                            n_ign = 1'b1;
                        end
                        K_CAPTURE: begin
                            if (r_sync) begin
                                n_syn = 1'b1;
                                if (r_slot >= i_cfg.min_channels) begin
                                    n_pub = r_slot;
                                    n_fp  = 1'b1;
                                    for (int i = 0; i < SLOT_COUNT; i++) begin
                                        if (CNT_W'(i) >= r_slot) begin
                                            n_widths[i] = '0;
                                        end
                                    end
                                end
                                n_slot = '0;
                            end else if (r_slot < NCH) begin
                                n_widths[r_slot[IW-1:0]] = r_width;
                                n_slot = r_slot + 1'b1;
                                if (r_slot + 1'b1 == NCH) begin
                                    n_pub = NCH;
                                    n_fp  = 1'b1;
                                end
                            end
                            n_prev = r_op.capture_count;
                        end
                        default: begin
                        end
                    endcase
                    n_cc        = n_pub;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev      <= '0;
            r_slot      <= '0;
            r_pub       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_widths[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_prev      <= n_prev;
            r_slot      <= n_slot;
            r_pub       <= n_pub;
            r_out_valid <= n_out_valid;
            r_widths    <= n_widths;
        end
        r_op    <= n_op;
        r_width <= n_width;
        r_sync  <= n_sync;
        r_rv    <= n_rv;
        r_cc    <= n_cc;
        r_ign   <= n_ign;
        r_syn   <= n_syn;
        r_fp    <= n_fp;
    end

    assign o_out_valid       = r_out_valid;
    assign o_read_value      = r_rv;
    assign o_channel_count   = r_cc;
    assign o_sample_ignored  = r_ign;
    assign o_sync_detected   = r_syn;
    assign o_frame_published = r_fp;

endmodule

// ===== hw/rtl/ppm_sum_channel_decoder_unit.sv =====
`timescale 1ns / 1ps

// PPM-sum decoder: capture items (timer count at each falling edge) give pulse widths that
// fill channel slots, a width above the sync threshold closes the frame, and read items
// return one stored slot. Every item gives exactly one result. The front stage takes an
// item per cycle, while the queue is not full, into a two-entry queue; the back sequencer
// works one item at a time through fetch, width unwrap and compare, and state update, and
// takes no new item until the last is through; a result passes the front register, the
// queue and these steps before it is offered. Clearing the unfilled slots at a publishing
// sync happens within the update cycle. Configuration writes are taken at any time with
// ready held high and must only be issued while the block is idle.

module ppm_sum_channel_decoder_unit
    import ppmsum_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_mode,
    input  logic [WIDTH_W-1:0]   i_capture_count,
    input  logic                 i_overcapture,
    input  logic [IDX_W-1:0]     i_channel_index,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [WIDTH_W-1:0]   o_read_value,
    output logic [CNT_W-1:0]     o_channel_count,
    output logic                 o_sample_ignored,
    output logic                 o_sync_detected,
    output logic                 o_frame_published,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WIDTH_W-1:0]   i_cfg_data
);

    t_cfg r_cfg;
    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_empty;
    t_op  w_front_op;
    t_op  w_head_op;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_threshold <= SYNC_RESET;
            r_cfg.timer_reload   <= RELOAD_RESET;
            r_cfg.min_channels   <= MINCH_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SYNC_THRESHOLD: r_cfg.sync_threshold <= i_cfg_data;
                CFG_TIMER_RELOAD:   r_cfg.timer_reload   <= i_cfg_data;
                CFG_MIN_CHANNELS:   r_cfg.min_channels   <= i_cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ppmsum_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_capture_count (i_capture_count),
        .i_overcapture   (i_overcapture),
        .i_channel_index (i_channel_index),
        .o_push          (w_push),
        .o_op            (w_front_op),
        .i_full          (w_full)
    );

    ppmsum_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_front_op),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_op    (w_head_op),
        .o_empty (w_empty)
    );

    ppmsum_back #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_empty           (w_empty),
        .i_op              (w_head_op),
        .o_pop             (w_pop),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_read_value      (o_read_value),
        .o_channel_count   (o_channel_count),
        .o_sample_ignored  (o_sample_ignored),
        .o_sync_detected   (o_sync_detected),
        .o_frame_published (o_frame_published)
    );

endmodule

// ===== hw/rtl/ppmsum_checker.sv =====
`timescale 1ns / 1ps

module ppmsum_checker
    import ppmsum_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [WIDTH_W-1:0] o_read_value,
    input logic [CNT_W-1:0]   o_channel_count,
    input logic               o_sample_ignored,
    input logic               o_sync_detected,
    input logic               o_frame_published
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_read_value) && $stable(o_channel_count)
            && $stable(o_sync_detected) && $stable(o_frame_published))
        else $error("result changed while stalled");

    // a dropped capture has no other effect flags
    a_ignored_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_sample_ignored |->
            !o_sync_detected && !o_frame_published && o_read_value == '0)
        else $error("ignored sample with other flags");

    // publishing without sync only on a full set of slots
    a_full_publish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_published && !o_sync_detected |->
            o_channel_count == CNT_W'(SLOT_COUNT))
        else $error("publish without sync on a partial frame");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_channel_count <= CNT_W'(SLOT_COUNT))
        else $error("channel count out of range");

endmodule

bind ppm_sum_channel_decoder_unit ppmsum_checker #(
    .SLOT_COUNT (SLOT_COUNT)
) u_ppmsum_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_read_value      (o_read_value),
    .o_channel_count   (o_channel_count),
    .o_sample_ignored  (o_sample_ignored),
    .o_sync_detected   (o_sync_detected),
    .o_frame_published (o_frame_published)
);

// ===== test/tb_ppm_sum_channel_decoder_unit.sv =====
`timescale 1ns / 1ps

module tb_ppm_sum_channel_decoder_unit;
    import ppmsum_pkg::*;

    localparam int NUM_CH         = SLOT_COUNT_DEF;
    localparam int RANDOM_ITEMS   = 400;
    localparam int DRAIN_CYCLES   = 12;
    // longest quiet stretch in a correct run is a long sender gap or a forced stall window
    localparam int WATCHDOG_LIMIT = 3000;

    localparam logic MODE_CAPTURE = 1'b0;
    localparam logic MODE_READ    = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [WIDTH_W-1:0] read_value;
        logic [CNT_W-1:0]   channel_count;
        logic               sample_ignored;
        logic               sync_detected;
        logic               frame_published;
    } t_decode_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic                 i_mode = MODE_CAPTURE;
    logic [WIDTH_W-1:0]   i_capture_count = '0;
    logic                 i_overcapture = 1'b0;
    logic [IDX_W-1:0]     i_channel_index = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [WIDTH_W-1:0]   o_read_value;
    logic [CNT_W-1:0]     o_channel_count;
    logic                 o_sample_ignored;
    logic                 o_sync_detected;
    logic                 o_frame_published;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [WIDTH_W-1:0]   i_cfg_data = '0;

    // decoder state as the testbench sees it
    logic [WIDTH_W-1:0] sync_thr;
    logic [WIDTH_W-1:0] reload_val;
    logic [CNT_W-1:0]   min_ch;
    logic [WIDTH_W-1:0] last_capture;
    logic [CNT_W-1:0]   slots_filled;
    logic [WIDTH_W-1:0] slot_width [NUM_CH];
    logic [CNT_W-1:0]   published_n;
    t_decode_result     decoded_q [$];

    int  burst_left = 0;
    bit  gaps_on = 1'b1;
    int  stall_pct = 0;
    logic [6:0] ready_tick = '0;
    int  quiet_cycles = 0;
    int  mismatch_count = 0;
    int  items_sent = 0;
    int  cfg_writes = 0;
    int  n_checked = 0;
    int  n_syncs = 0;
    int  n_published = 0;
    int  n_dropped = 0;

    ppm_sum_channel_decoder_unit u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_mode            (i_mode),
        .i_capture_count   (i_capture_count),
        .i_overcapture     (i_overcapture),
        .i_channel_index   (i_channel_index),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_read_value      (o_read_value),
        .o_channel_count   (o_channel_count),
        .o_sample_ignored  (o_sample_ignored),
        .o_sync_detected   (o_sync_detected),
        .o_frame_published (o_frame_published),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_decode_result decode_pulse(input logic rd, input logic [15:0] cap,
                                                    input logic lost, input logic [3:0] idx);
        t_decode_result r;
        int w;
        r = '0;
        if (rd == MODE_READ) begin
            if (idx < NUM_CH)
                r.read_value = slot_width[idx];
        end else if (lost) begin
            r.sample_ignored = 1'b1;
        end else begin
            if (cap >= last_capture)
                w = int'(cap) - int'(last_capture);
            else
                w = int'(cap) + int'(reload_val) - int'(last_capture);
            if (w < 0)
                w = 0;
            else if (w > 65535)
                w = 65535;
            if (w > int'(sync_thr)) begin
                r.sync_detected = 1'b1;
                if (slots_filled >= min_ch) begin
                    published_n = slots_filled;
                    r.frame_published = 1'b1;
                    for (int i = 0; i < NUM_CH; i++)
                        if (i >= slots_filled)
                            slot_width[i] = '0;
                end
                slots_filled = '0;
            end else if (slots_filled < NUM_CH) begin
                slot_width[slots_filled[IDX_W-1:0]] = w[15:0];
                slots_filled = slots_filled + 1'b1;
                if (slots_filled == NUM_CH) begin
                    published_n = CNT_W'(NUM_CH);
                    r.frame_published = 1'b1;
                end
            end
            last_capture = cap;
        end
        r.channel_count = published_n;
        return r;
    endfunction

    // entered and left at a falling edge; valid stays high across a burst
    task automatic send_item(input logic rd, input logic [15:0] cap, input logic lost,
                             input logic [3:0] idx);
        if (burst_left == 0) begin
            if (gaps_on) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 25 : 5))
                    @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        i_in_valid      <= 1'b1;
        i_mode          <= rd;
        i_capture_count <= cap;
        i_overcapture   <= lost;
        i_channel_index <= idx;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        decoded_q.push_back(decode_pulse(rd, cap, lost, idx));
        items_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic send_capture(input logic [15:0] cap);
        send_item(MODE_CAPTURE, cap, 1'b0, 4'($urandom));
    endtask

    // capture that lands a given pulse width after the last one, wrapping at the reload
    task automatic send_width(input int w);
        send_capture(16'((int'(last_capture) + w) % int'(reload_val)));
    endtask

    task automatic send_read(input logic [3:0] idx);
        send_item(MODE_READ, 16'($urandom), 1'($urandom), idx);
    endtask

    task automatic send_lost();
        send_item(MODE_CAPTURE, 16'($urandom), 1'b1, 4'($urandom));
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (decoded_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_SYNC_THRESHOLD: sync_thr = data;
            CFG_TIMER_RELOAD:   reload_val = data;
            CFG_MIN_CHANNELS:   min_ch = data[CNT_W-1:0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic test_reset_and_reads();
        stall_pct = 0;
        gaps_on   = 1'b0;
        send_read(4'd0);
        send_read(4'd15);
        send_item(MODE_CAPTURE, 16'hFFFF, 1'b1, 4'hF);
        send_item(MODE_READ, 16'hFFFF, 1'b1, 4'd10);
    endtask

    task automatic test_frame_and_wrap();
        stall_pct = 30;
        gaps_on   = 1'b1;
        send_capture(16'd0);
        send_capture(16'd20000);
        // a width equal to the threshold is still a channel
        send_width(8000);
        send_width(1000);
        send_width(2000);
        send_width(1500);
        send_width(1200);
        send_width(8001);
        send_capture(16'hFFFF);
        // reload below the backwards step gives a negative width, held at zero
        send_capture(16'd100);
        send_capture(16'd59000);
        send_width(1800);
    endtask

    task automatic test_register_extremes();
        settle();
        write_reg(CFG_MIN_CHANNELS, 16'd0);
        write_reg(CFG_SYNC_THRESHOLD, 16'd1000);
        send_width(1500);
        send_width(2000);

        // min above the slot count: only a full set publishes, extra widths are dropped
        settle();
        write_reg(CFG_MIN_CHANNELS, 16'd16);
        write_reg(CFG_SYNC_THRESHOLD, 16'd3000);
        for (int i = 0; i < NUM_CH + 1; i++)
            send_width(100 * (i + 1));
        send_width(3001);

        settle();
        write_reg(CFG_TIMER_RELOAD, 16'd1);
        write_reg(CFG_SYNC_THRESHOLD, 16'd0);
        send_capture(16'd5000);
        send_capture(16'd4000);
        send_capture(16'hFFFF);

        settle();
        write_reg(CFG_TIMER_RELOAD, 16'hFFFF);
        write_reg(CFG_SYNC_THRESHOLD, 16'hFFFF);
        write_reg(CFG_UNUSED, 16'($urandom));
        send_capture(16'd0);
    endtask

    // one frame: a sync gap then a run of channel widths, with some noise mixed in
    task automatic send_frame();
        int n;
        int thr;
        int rel;
        thr = int'(sync_thr);
        rel = int'(reload_val);
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : $urandom_range(4, 10);
        if (rel > thr + 1)
            send_width($urandom_range(thr + 1, rel - 1));
        else
            send_capture(16'($urandom));
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 19))
                0:       send_lost();
                1:       send_read(4'($urandom));
                2:       send_capture(16'($urandom));
                default: send_width($urandom_range(0, thr));
            endcase
        end
        if ($urandom_range(0, 2) == 0)
            send_read(4'($urandom_range(0, 15)));
    endtask

    task automatic test_random_traffic();
        int target;
        int thr;
        for (int phase = 0; phase < 4; phase++) begin
            settle();
            thr = $urandom_range(300, 20000);
            case (phase)
                0: begin
                    stall_pct = 0;
                    gaps_on   = 1'b0;
                    write_reg(CFG_SYNC_THRESHOLD, SYNC_RESET);
                    write_reg(CFG_TIMER_RELOAD, RELOAD_RESET);
                    write_reg(CFG_MIN_CHANNELS, 16'(MINCH_RESET));
                end
                1: begin
                    stall_pct = 30;
                    gaps_on   = 1'b1;
                    write_reg(CFG_SYNC_THRESHOLD, 16'(thr));
                    write_reg(CFG_TIMER_RELOAD, 16'($urandom_range(thr + 2, 65535)));
                    write_reg(CFG_MIN_CHANNELS, 16'($urandom_range(0, 16)));
                end
                2: begin
                    stall_pct = 70;
                    gaps_on   = 1'b1;
                    write_reg(CFG_SYNC_THRESHOLD, 16'(thr));
                    write_reg(CFG_TIMER_RELOAD, 16'hFFFF);
                    write_reg(CFG_MIN_CHANNELS, 16'd16);
                end
                default: begin
                    stall_pct = 20;
                    gaps_on   = 1'b1;
                    write_reg(CFG_SYNC_THRESHOLD, 16'(thr));
                    write_reg(CFG_TIMER_RELOAD, 16'($urandom_range(thr + 2, 65535)));
                    write_reg(CFG_MIN_CHANNELS, 16'd0);
                end
            endcase
            target = items_sent + RANDOM_ITEMS / 4;
            while (items_sent < target)
                send_frame();
        end
    endtask

    // random stalls plus a recurring forced stall window, both off while stall_pct is zero
    always @(negedge i_clk) begin
        ready_tick <= ready_tick + 1'b1;
        if (stall_pct == 0)
            i_out_ready <= 1'b1;
        else if (ready_tick[6:4] == 3'b101)
            i_out_ready <= 1'b0;
        else
            i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_decode_result want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got read_value %0d count %0d",
                         $time, o_read_value, o_channel_count);
                mismatch_count++;
            end else begin
                want = decoded_q.pop_front();
                check_field("read_value", want.read_value, o_read_value);
                check_field("channel_count", 16'(want.channel_count), 16'(o_channel_count));
                check_field("sample_ignored", 16'(want.sample_ignored), 16'(o_sample_ignored));
                check_field("sync_detected", 16'(want.sync_detected), 16'(o_sync_detected));
                check_field("frame_published", 16'(want.frame_published),
                            16'(o_frame_published));
                n_checked++;
                if (want.sync_detected)
                    n_syncs++;
                if (want.frame_published)
                    n_published++;
                if (want.sample_ignored)
                    n_dropped++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, decoded_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        sync_thr     = SYNC_RESET;
        reload_val   = RELOAD_RESET;
        min_ch       = MINCH_RESET;
        last_capture = '0;
        slots_filled = '0;
        published_n  = '0;
        foreach (slot_width[i])
            slot_width[i] = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_and_reads();
        test_frame_and_wrap();
        test_register_extremes();
        test_random_traffic();
        settle();

        $display("run covered %0d items and %0d register writes; %0d results checked",
                 items_sent, cfg_writes, n_checked);
        $display("%0d sync gaps, %0d frames published, %0d captures dropped, %0d mismatches",
                 n_syncs, n_published, n_dropped, mismatch_count);
        if (mismatch_count == 0 && decoded_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/ppmsum_pkg.sv
hw/rtl/ppmsum_front.sv
hw/rtl/ppmsum_fifo.sv
hw/rtl/ppmsum_back.sv
hw/rtl/ppm_sum_channel_decoder_unit.sv
hw/rtl/ppmsum_checker.sv
test/tb_ppm_sum_channel_decoder_unit.sv
